[design/grm_pkg.sv]
package grm_pkg;

    localparam int BlockPixels   = 64;
    localparam int MapRows       = 32;
    localparam int MapCols       = 32;
    localparam int FracBits      = 8;
    localparam int FineStepShift = 7;

    localparam int PosShift  = 14 + FineStepShift - FracBits;
    localparam int CoarseCap = 2 * (MapRows + MapCols) * BlockPixels;
    localparam int BlkShift  = $clog2(BlockPixels);
    localparam int DistShift = BlkShift + FineStepShift - FracBits;
    localparam int DistMax   = 16383;

    localparam int PosW  = 19;
    localparam int MW    = $clog2(CoarseCap + 2);
    localparam int NW    = MW + FineStepShift + 1;
    localparam int ProdW = NW + 16;
    localparam int CoordW = ProdW + 2;
    localparam int CellW = $clog2(MapRows * MapCols);

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdCast  = 1'b1;

    typedef enum logic [1:0] {
        t_probe_open = 2'd0,
        t_probe_wall = 2'd1,
        t_probe_off  = 2'd2
    } t_probe;

    typedef enum logic [2:0] {
        t_op_idle    = 3'd0,
        t_op_write   = 3'd1,
        t_op_trig    = 3'd2,
        t_op_probe   = 3'd3,
        t_op_clear   = 3'd4
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [NW-1:0]       n;
    } t_cmd;

    typedef struct packed {
        logic   done;
        t_probe code;
    } t_status;

endpackage

[design/grm_datapath.sv]
module grm_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  grm_pkg::t_cmd             i_cmd,
    output grm_pkg::t_status          o_status,
    input  logic [4:0]                i_row,
    input  logic [4:0]                i_col,
    input  logic                      i_wall,
    input  logic [15:0]               i_angle,
    input  logic [grm_pkg::PosW-1:0]  i_pos_x,
    input  logic [grm_pkg::PosW-1:0]  i_pos_y
);
    import grm_pkg::*;

    logic                     wall_map [MapRows*MapCols];
    logic signed [15:0]       r_cos, r_sin;
    logic [14:0]              r_t, r_t2, r_r;
    logic [2:0]               r_tstep;
    logic                     r_tsel;
    logic [1:0]               r_q;
    logic [2:0]               r_pstep;
    logic signed [ProdW-1:0]  r_px, r_py;
    logic signed [CoordW-1:0] r_x, r_y;
    logic [CellW-1:0]         r_addr;
    logic                     r_off;
    logic                     r_rd;
    logic                     r_done;
    t_probe                   r_code;

    logic [15:0] w_a;
    logic [14:0] w_f;
    logic [28:0] w_mul;
    logic signed [ProdW-1:0]  w_nx, w_ny;
    logic [CoordW-1:0] w_pixx, w_pixy;
    logic [CoordW-1:0] w_colx, w_rowy;

    // cosine pass loads at step 0, sine pass loads at step 5
    assign w_a = (r_tstep == 3'd5) ? i_angle : i_angle + 16'd16384;
    assign w_f = w_a[14] ? 15'd16384 - {1'b0, w_a[13:0]} : {1'b0, w_a[13:0]};

    always_comb begin
        w_mul = '0;
        case (r_tstep)
            3'd1: w_mul = 29'(r_t) * 29'(r_t);
            3'd2: w_mul = 29'(15'd1160) * 29'(r_t2);
            3'd3: w_mul = 29'(15'd10512 - r_r) * 29'(r_t2);
            3'd4: w_mul = 29'(15'd25736 - r_r) * 29'(r_t);
            default: w_mul = '0;
        endcase
    end

    assign w_nx = ProdW'(signed'({1'b0, i_cmd.n})) * ProdW'(r_cos);
    assign w_ny = ProdW'(signed'({1'b0, i_cmd.n})) * ProdW'(r_sin);
    assign w_pixx = CoordW'(r_x) >> FracBits;
    assign w_pixy = CoordW'(r_y) >> FracBits;
    assign w_colx = w_pixx >> BlkShift;
    assign w_rowy = w_pixy >> BlkShift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tstep <= '0;
            r_pstep <= '0;
            r_done  <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rd   <= 1'b0;
            unique case (i_cmd.op)
                t_op_clear: begin
                    wall_map[i_cmd.n[CellW-1:0]] <= 1'b0;
                    r_done <= 1'b1;
                end
                t_op_write: begin
                    wall_map[{i_row, i_col}] <= i_wall;
                    r_done <= 1'b1;
                end
                t_op_trig: begin
                    if (r_tstep == 3'd0) begin
                        r_tsel  <= 1'b0;
                        r_q     <= w_a[15:14];
                        r_t     <= w_f;
                        r_tstep <= 3'd1;
                    end else if (r_tstep == 3'd5) begin
                        if (r_tsel) begin
                            r_tstep <= 3'd0;
                            r_done  <= 1'b1;
                        end else begin
                            r_tsel  <= 1'b1;
                            r_q     <= w_a[15:14];
                            r_t     <= w_f;
                            r_tstep <= 3'd1;
                        end
                    end else begin
                        r_tstep <= r_tstep + 3'd1;
                        case (r_tstep)
                            3'd1: r_t2 <= 15'(w_mul >> 14);
                            3'd2, 3'd3: r_r <= 15'(w_mul >> 14);
                            default: begin
                                if (r_tsel)
                                    r_sin <= r_q[1] ? -16'(w_mul >> 14) : 16'(w_mul >> 14);
                                else
                                    r_cos <= r_q[1] ? -16'(w_mul >> 14) : 16'(w_mul >> 14);
                            end
                        endcase
                    end
                end
                t_op_probe: begin
                    r_pstep <= r_pstep + 3'd1;
                    case (r_pstep)
                        3'd0: begin
                            r_px <= w_nx;
                            r_py <= w_ny;
                        end
                        3'd1: begin
                            r_x <= CoordW'(signed'({1'b0, i_pos_x})) + CoordW'(r_px >>> PosShift);
                            r_y <= CoordW'(signed'({1'b0, i_pos_y})) + CoordW'(r_py >>> PosShift);
                        end
                        3'd2: begin
                            r_off  <= r_x[CoordW-1] || r_y[CoordW-1] ||
                                      w_colx >= CoordW'(MapCols) || w_rowy >= CoordW'(MapRows);
                            r_addr <= CellW'((w_rowy % CoordW'(MapRows)) * CoordW'(MapCols)
                                      + w_colx % CoordW'(MapCols));
                        end
                        3'd3: r_rd <= wall_map[r_addr];
                        default: begin
                            r_pstep <= '0;
                            r_done  <= 1'b1;
                            r_code  <= r_off ? t_probe_off : (r_rd ? t_probe_wall : t_probe_open);
                        end
                    endcase
                end
                default: begin
                    r_tstep <= '0;
                    r_pstep <= '0;
                end
            endcase
        end
    end

    assign o_status.done = r_done;
    assign o_status.code = r_code;

    a_tstep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tstep <= 3'd5) else $error("trig step out of range");
    a_pstep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pstep <= 3'd4) else $error("probe step out of range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held two cycles");
endmodule

[design/grm_ctrl.sv]
module grm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [13:0]          o_dist,
    output logic                 o_left,
    output logic                 o_cast,
    output grm_pkg::t_cmd        o_cmd,
    input  grm_pkg::t_status     i_status
);
    import grm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_TRIG, S_P0, S_COARSE, S_FINE0, S_FINE, S_OUT
    } t_state;

    t_state          r_state;
    logic [NW-1:0]   r_n;
    logic [MW-1:0]   r_m;
    logic [NW-1:0]   r_n0;
    logic [FineStepShift:0] r_k;
    logic            r_out_valid, r_left, r_cast;
    logic [13:0]     r_dist;
    logic [NW-1:0]   w_fin;
    logic [NW-1:0]   w_dq;

    assign w_fin = r_n0 + NW'(r_k) + NW'(2);
    assign w_dq  = w_fin >> DistShift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (i_status.done) begin
                        if (r_n == NW'(MapRows*MapCols-1)) r_state <= S_IDLE;
                        r_n <= r_n + NW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && !r_out_valid) begin
                        if (i_command == CmdWrite) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_TRIG;
                        end
                    end
                end
                S_WRITE: begin
                    if (i_status.done) begin
                        r_dist <= '0; r_left <= 1'b0; r_cast <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_TRIG: begin
                    if (i_status.done) begin
                        r_n <= '0; r_m <= '0;
                        r_state <= S_P0;
                    end
                end
                S_P0: begin
                    if (i_status.done) begin
                        if (i_status.code == t_probe_open) begin
                            r_m <= MW'(1);
                            r_n <= NW'(1) << FineStepShift;
                            r_state <= S_COARSE;
                        end else begin
                            r_n0 <= '0; r_n <= '0;
                            r_state <= S_FINE0;
                        end
                    end
                end
                S_COARSE: begin
                    if (i_status.done) begin
                        if (i_status.code != t_probe_open) begin
                            r_n0 <= NW'(r_m - MW'(1)) << FineStepShift;
                            r_n  <= NW'(r_m - MW'(1)) << FineStepShift;
                            r_state <= S_FINE0;
                        end else if (r_m == MW'(CoarseCap)) begin
                            r_n0 <= NW'(r_m) << FineStepShift;
                            r_n  <= NW'(r_m) << FineStepShift;
                            r_state <= S_FINE0;
                        end else begin
                            r_m <= r_m + MW'(1);
                            r_n <= r_n + (NW'(1) << FineStepShift);
                        end
                    end
                end
                S_FINE0: begin
                    if (i_status.done) begin
                        if (i_status.code == t_probe_open) begin
                            r_k <= '0;
                            r_n <= r_n0 + NW'(1);
                            r_state <= S_FINE;
                        end else begin
                            r_dist <= '0;
                            r_left <= (i_status.code == t_probe_off);
                            r_cast <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_FINE: begin
                    if (i_status.done) begin
                        if (i_status.code != t_probe_open ||
                            r_k + 1'b1 >= (FineStepShift+1)'(1 << FineStepShift)) begin
                            r_k <= r_k + 1'b1;
                            r_dist <= 14'((w_dq > NW'(DistMax)) ? NW'(DistMax) : w_dq);
                            r_left <= (i_status.code != t_probe_wall);
                            r_cast <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_n <= r_n + NW'(1);
                        end
                    end
                end
                default: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_dist = r_dist;
    assign o_left = r_left;
    assign o_cast = r_cast;

    always_comb begin
        o_cmd.n  = r_n;
        o_cmd.op = t_op_idle;
        case (r_state)
            S_CLEAR: o_cmd.op = i_status.done ? t_op_idle : t_op_clear;
            S_WRITE: o_cmd.op = i_status.done ? t_op_idle : t_op_write;
            S_TRIG:  o_cmd.op = i_status.done ? t_op_idle : t_op_trig;
            S_P0, S_COARSE, S_FINE0, S_FINE:
                     o_cmd.op = i_status.done ? t_op_idle : t_op_probe;
            default: o_cmd.op = t_op_idle;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_cast) |-> (r_dist == '0 && !r_left))
        else $error("write acknowledge carries data");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINE |-> r_k < (FineStepShift+1)'(1 << FineStepShift))
        else $error("fine step runaway");
endmodule

[design/grid_ray_march_distance.sv]
// a map write returns a result; a ray cast computes sine and cosine, then probes once
// per pixel over the coarse walk, once more at the back-off point and once per fine step
// after that; one request in flight, the next is taken only once the result has left;
// reset: synchronous active low; a clearing pass sets every map cell open before the
// first input request is taken
module grid_ray_march_distance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // cell_row, cell_col, cell_is_wall, ray_angle
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // distance_blocks, left_map
    output logic        m_axis_tuser,   // is_cast_result
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [18:0] i_cfg_data
);
    import grm_pkg::*;

    logic [PosW-1:0] r_pos_x, r_pos_y;
    logic [26:0]     r_in;
    logic            r_cmd;
    t_cmd            w_cmd;
    t_status         w_status;
    logic [13:0]     w_dist;
    logic            w_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) r_pos_x <= i_cfg_data;
            else                     r_pos_y <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in  <= s_axis_tdata[26:0];
            r_cmd <= s_axis_tuser;
        end
    end

    assign o_cfg_ready = 1'b1;

    grm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_command   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dist      (w_dist),
        .o_left      (w_left),
        .o_cast      (m_axis_tuser),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    grm_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_row    (r_in[4:0]),
        .i_col    (r_in[9:5]),
        .i_wall   (r_in[10] & ~r_cmd),
        .i_angle  (r_in[26:11]),
        .i_pos_x  (r_pos_x),
        .i_pos_y  (r_pos_y)
    );

    assign m_axis_tdata = {1'b0, w_left, w_dist};
endmodule
